### rtl/core/tpt_one_pole_lowpass_core_defines.svh
// ----------------------------------------------------------------------------
// tpt_one_pole_lowpass_core_defines
// assertion macros shared by the checker files of the lowpass core
// ----------------------------------------------------------------------------
`ifndef TPT_ONE_POLE_LOWPASS_CORE_DEFINES_SVH
`define TPT_ONE_POLE_LOWPASS_CORE_DEFINES_SVH

// property checked on every clock edge outside reset
`define TPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define TPT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/core/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg
// types, constants and helpers of the trapezoidal one-pole lowpass core
// ----------------------------------------------------------------------------
package tpt_pkg;

    // request codes
    localparam logic REQ_FILTER = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    // register word index
    localparam logic REG_SAMPLE_RATE = 1'b0;

    // channel address field of the state memory, covers up to 64 channels
    localparam int CH_W = 6;

    // numeric constants
    localparam logic [23:0] F_MAX_Q24    = 24'd8338276;
    localparam logic [31:0] PI_Q30       = 32'd3373259426;
    localparam logic [31:0] G_MAX        = 32'h7FFF_FFFF;
    localparam logic [17:0] SR_RESET     = 18'd48000;
    localparam int          CORDIC_STEPS = 30;
    localparam int          DIV_STEPS    = 64;

    // divider request and response
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

    // rotation unit request and response
    typedef struct packed {
        logic        start;
        logic [33:0] theta;
    } t_cor_req;

    typedef struct packed {
        logic               done;
        logic signed [33:0] x;
        logic signed [33:0] y;
    } t_cor_rsp;

    // state memory access
    typedef struct packed {
        logic            rd;
        logic            wr;
        logic            clr;
        logic [CH_W-1:0] addr;
        logic [31:0]     wdata;
    } t_mem_req;

    // arctangent of 2^-i in Q.30
    function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:    v = 34'sd843314857;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043837;
            5'd3:    v = 34'sd133525159;
            5'd4:    v = 34'sd67021687;
            5'd5:    v = 34'sd33543516;
            5'd6:    v = 34'sd16775851;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194283;
            5'd9:    v = 34'sd2097149;
            default: v = 34'sd1 <<< (5'd30 - i);
        endcase
        return v;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
        logic signed [31:0] r;
        if (v > 44'sh000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -44'sh000_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // clamp to the signed 24-bit range
    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        logic signed [23:0] r;
        if (v > 26'sd8388607) begin
            r = 24'sh7F_FFFF;
        end else if (v < -26'sd8388608) begin
            r = -24'sh80_0000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/tpt_in_if.sv
// ----------------------------------------------------------------------------
// tpt_in_if
// request channel of the lowpass core: one sample or one clear per transfer
// ----------------------------------------------------------------------------
interface tpt_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [2:0]         channel;
    logic signed [23:0] sample_in;
    logic signed [17:0] cutoff_hz;

    modport source (output valid, req_type, channel, sample_in, cutoff_hz, input ready);
    modport sink   (input valid, req_type, channel, sample_in, cutoff_hz, output ready);
endinterface

### rtl/core/tpt_out_if.sv
// ----------------------------------------------------------------------------
// tpt_out_if
// result channel of the lowpass core: one filtered sample per transfer
// ----------------------------------------------------------------------------
interface tpt_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         channel_out;
    logic signed [23:0] sample_out;

    modport source (output valid, channel_out, sample_out, input ready);
    modport sink   (input valid, channel_out, sample_out, output ready);
endinterface

### rtl/core/tpt_div.sv
// ----------------------------------------------------------------------------
// tpt_div
// restoring unsigned divider, one quotient bit per cycle, 64-bit dividend
// ----------------------------------------------------------------------------
module tpt_div
    import tpt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [32:0] r_rem;
    logic [63:0] r_quot;
    logic [32:0] r_div;

    logic [33:0] w_shift;
    logic        w_ge;
    logic [33:0] w_sub;

    // one trial subtraction
    assign w_shift = {r_rem, r_quot[63]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_sub   = w_shift - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shifter
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quot <= i_req.dividend;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_sub[32:0] : w_shift[32:0];
            r_quot <= {r_quot[62:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

### rtl/core/tpt_cordic.sv
// ----------------------------------------------------------------------------
// tpt_cordic
// rotation-mode cordic, one micro-rotation per cycle, gives scaled cos and sin
// ----------------------------------------------------------------------------
module tpt_cordic
    import tpt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cor_req i_req,
    output t_cor_rsp o_rsp
);

    logic               r_busy;
    logic               r_done;
    logic [4:0]         r_i;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;

    logic signed [33:0] w_dx;
    logic signed [33:0] w_dy;
    logic signed [33:0] w_at;

    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_at = atan_entry(r_i);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 5'd1;
                if (r_i == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // micro-rotation towards zero residual angle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x <= 34'sd1 <<< 29;
            r_y <= '0;
            r_z <= i_req.theta;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.x    = r_x;
    assign o_rsp.y    = r_y;

endmodule

### rtl/core/tpt_state_mem.sv
// ----------------------------------------------------------------------------
// tpt_state_mem
// per-channel filter state memory, registered read, valid bits for clearing
// ----------------------------------------------------------------------------
module tpt_state_mem
    import tpt_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mem_req           i_req,
    output logic signed [31:0] o_rdata
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [31:0]         r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_valid;
    logic [31:0]         r_rdata;
    logic                r_rvalid;
    logic [AW-1:0]       w_idx;

    assign w_idx = i_req.addr[AW-1:0];

    // entry valid bits, cleared at once by reset or a clear request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.clr) begin
            r_valid <= '0;
        end else if (i_req.wr) begin
            r_valid[w_idx] <= 1'b1;
        end
    end

    // storage write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[w_idx] <= i_req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_rdata  <= r_mem[w_idx];
            r_rvalid <= r_valid[w_idx];
        end
    end

    // an entry never written since the last clear reads as zero
    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

### rtl/core/tpt_one_pole_lowpass_core.sv
// ----------------------------------------------------------------------------
// tpt_one_pole_lowpass_core
// multichannel trapezoidal one-pole lowpass, fixed point, state in memory
//
//   channel  | dir | kind         | content
//   i_req    | in  | valid/ready  | req_type, channel, sample_in, cutoff_hz
//   o_res    | out | valid/ready  | channel_out, sample_out
//   apb      | in  | apb write/rd | sample_rate at byte address 0
//
// A filter request passes through up to three divides on the shared bit-serial
// divider (cutoff over rate, tan, lowpass), the cordic and the single steps of
// the sequencer; the first divide is skipped when the cutoff is not positive or
// the rate is zero, the tan divide when the cordic x result is not positive.
// A clear request or an unused channel goes straight to the output step.
// One request at a time; the next is taken while a result still waits at
// o_res, and the last step stalls until that result has left.
// Reset is synchronous; all state entries read as zero after reset.
// ----------------------------------------------------------------------------
module tpt_one_pole_lowpass_core
    import tpt_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tpt_in_if.sink       i_req,
    tpt_out_if.source    o_res,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_FQ, S_FQ_WAIT, S_THETA, S_COR, S_COR_WAIT, S_G, S_G_WAIT,
        S_NUM, S_SUM, S_LP, S_LP_WAIT, S_NS, S_WB, S_OUT
    } t_state;

    t_state             r_state;
    logic [17:0]        r_sample_rate;
    logic [2:0]         r_ch;
    logic signed [30:0] r_x30;
    logic signed [17:0] r_cut;
    logic [23:0]        r_fq;
    logic [33:0]        r_theta;
    logic signed [33:0] r_cx;
    logic signed [33:0] r_cy;
    logic [31:0]        r_g;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_num;
    logic signed [32:0] r_lp;
    logic signed [66:0] r_nprod;
    logic signed [23:0] r_res;
    logic               r_ovalid;
    logic [2:0]         r_och;
    logic signed [23:0] r_osample;

    t_div_req           w_dreq;
    t_div_rsp           w_drsp;
    t_cor_req           w_creq;
    t_cor_rsp           w_crsp;
    t_mem_req           w_mreq;
    logic signed [31:0] w_s;
    logic               w_acc;
    logic               w_take;
    logic               w_in_range;
    logic signed [32:0] w_gs;
    logic signed [33:0] w_diff;
    logic signed [43:0] w_ns;
    logic [63:0]        w_num_abs;
    logic signed [32:0] w_lp_mag;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SAMPLE_RATE) ? {14'd0, r_sample_rate} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= SR_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_SAMPLE_RATE) begin
            r_sample_rate <= pwdata[17:0];
        end
    end

    // handshakes
    assign i_req.ready       = (r_state == S_IDLE);
    assign w_acc             = i_req.valid && i_req.ready;
    assign w_take            = !r_ovalid || o_res.ready;
    assign w_in_range        = (32'(i_req.channel) < 32'(CHANNELS));
    assign o_res.valid       = r_ovalid;
    assign o_res.channel_out = r_och;
    assign o_res.sample_out  = r_osample;

    // arithmetic around the stored state
    assign w_gs      = $signed({1'b0, r_g});
    assign w_diff    = 34'(r_x30) - 34'(r_lp);
    assign w_ns      = 44'(r_nprod >>> 24) + 44'(r_lp);
    assign w_num_abs = r_num[63] ? 64'(-r_num) : 64'(r_num);
    assign w_lp_mag  = $signed({1'b0, w_drsp.quot[31:0]});

    // divider operands by step
    always_comb begin
        w_dreq = '0;
        case (r_state)
            S_FQ: begin
                w_dreq.start    = (r_cut > 18'sd0) && (r_sample_rate != 18'd0);
                w_dreq.dividend = {23'd0, r_cut[16:0], 24'd0};
                w_dreq.divisor  = {15'd0, r_sample_rate};
            end
            S_G: begin
                w_dreq.start    = 1'b1;
                w_dreq.dividend = {6'd0, r_cy, 24'd0};
                w_dreq.divisor  = r_cx[32:0];
            end
            S_LP: begin
                w_dreq.start    = 1'b1;
                w_dreq.dividend = w_num_abs;
                w_dreq.divisor  = 33'(r_g) + 33'h100_0000;
            end
            default: w_dreq = '0;
        endcase
    end

    assign w_creq.start = (r_state == S_COR);
    assign w_creq.theta = r_theta;

    // state memory: read on accept, write back at the end, clear on request
    always_comb begin
        w_mreq       = '0;
        w_mreq.rd    = w_acc && (i_req.req_type == REQ_FILTER) && w_in_range;
        w_mreq.clr   = w_acc && (i_req.req_type == REQ_CLEAR);
        w_mreq.wr    = (r_state == S_WB);
        w_mreq.addr  = (r_state == S_IDLE) ? CH_W'(i_req.channel) : CH_W'(r_ch);
        w_mreq.wdata = sat32(w_ns);
    end

    // sequencer with its registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // result leaves unless a new one is loaded in the same cycle
            if (r_ovalid && o_res.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_ch  <= i_req.channel;
                        r_x30 <= $signed({i_req.sample_in, 7'd0});
                        r_cut <= i_req.cutoff_hz;
                        r_res <= '0;
                        if (i_req.req_type == REQ_CLEAR || !w_in_range) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_FQ;
                        end
                    end
                end
                S_FQ: begin
                    if (r_cut <= 18'sd0) begin
                        r_fq    <= '0;
                        r_state <= S_THETA;
                    end else if (r_sample_rate == 18'd0) begin
                        r_fq    <= F_MAX_Q24;
                        r_state <= S_THETA;
                    end else begin
                        r_state <= S_FQ_WAIT;
                    end
                end
                S_FQ_WAIT: begin
                    if (w_drsp.done) begin
                        r_fq    <= (w_drsp.quot > 64'(F_MAX_Q24)) ? F_MAX_Q24
                                                              : w_drsp.quot[23:0];
                        r_state <= S_THETA;
                    end
                end
                S_THETA: begin
                    r_theta <= 34'((56'(r_fq) * 56'(PI_Q30)) >> 24);
                    r_state <= S_COR;
                end
                S_COR: begin
                    r_state <= S_COR_WAIT;
                end
                S_COR_WAIT: begin
                    if (w_crsp.done) begin
                        r_cx <= w_crsp.x;
                        r_cy <= w_crsp.y[33] ? 34'sd0 : w_crsp.y;
                        if (w_crsp.x <= 34'sd0) begin
                            r_g     <= G_MAX;
                            r_state <= S_NUM;
                        end else begin
                            r_state <= S_G;
                        end
                    end
                end
                S_G: begin
                    r_state <= S_G_WAIT;
                end
                S_G_WAIT: begin
                    if (w_drsp.done) begin
                        r_g     <= (w_drsp.quot > 64'(G_MAX)) ? G_MAX : w_drsp.quot[31:0];
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    r_prod  <= 64'(w_gs * r_x30);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_num   <= r_prod + (64'(w_s) <<< 24);
                    r_state <= S_LP;
                end
                S_LP: begin
                    r_state <= S_LP_WAIT;
                end
                S_LP_WAIT: begin
                    if (w_drsp.done) begin
                        r_lp    <= r_num[63] ? -w_lp_mag : w_lp_mag;
                        r_state <= S_NS;
                    end
                end
                S_NS: begin
                    r_nprod <= 67'(w_gs * w_diff);
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_res   <= sat24(26'(r_lp >>> 7));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_take) begin
                        r_ovalid  <= 1'b1;
                        r_och     <= r_ch;
                        r_osample <= r_res;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    tpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    tpt_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_creq),
        .o_rsp   (w_crsp)
    );

    tpt_state_mem #(
        .CHANNELS (CHANNELS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_rdata (w_s)
    );

endmodule

### rtl/core/tpt_core_checker.sv
// ----------------------------------------------------------------------------
// tpt_core_checker
// port-level checks of the lowpass core, bound to the top level
// ----------------------------------------------------------------------------
`include "tpt_one_pole_lowpass_core_defines.svh"

module tpt_core_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [23:0] i_out_sample,
    input logic        i_pready
);

    // config port never stalls
    `TPT_ASSERT(a_pready, i_pready, "pready low")

    // one request at a time: no second transfer right after a transfer
    `TPT_ASSERT(a_one_at_a_time, (i_in_valid && i_in_ready) |=> !i_in_ready, "ready after accept")

    // a stalled result keeps its value
    `TPT_ASSERT(a_out_hold, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_sample)), "result dropped")

    // reset leaves the block empty and ready
    `TPT_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!i_out_valid && i_in_ready), "not idle after reset")

endmodule

bind tpt_one_pole_lowpass_core tpt_core_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_sample (o_res.sample_out),
    .i_pready     (pready)
);

### dv/tpt_one_pole_lowpass_core_tb.sv
// ----------------------------------------------------------------------------
// tpt_one_pole_lowpass_core_tb
// drives filter and clear requests into the lowpass core over several sample
// rates, predicts each output sample with a fixed-point model of the tpt
// lowpass held here, and compares every result transfer field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tpt_one_pole_lowpass_core_tb;
    import tpt_pkg::*;

    localparam int NUM_CH = 8;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic               req_type;
        logic [2:0]         channel;
        logic signed [23:0] sample_in;
        logic signed [17:0] cutoff_hz;
    } t_item;

    typedef struct packed {
        logic [2:0]         channel_out;
        logic signed [23:0] sample_out;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tpt_in_if  req_if ();
    tpt_out_if res_if ();

    tpt_one_pole_lowpass_core #(.CHANNELS(NUM_CH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state and configuration
    logic [17:0]        rate_hz;
    logic signed [31:0] lp_state [NUM_CH];

    t_item   pending_q [$];
    t_result expected_q [$];
    int      errors = 0;
    longint  cycles = 0;
    int      hold_off = 0;

    // floor division by 2^s
    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint arctan_q30(input int i);
        longint t [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                           33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10) return t[i];
        return longint'(1) << (30 - i);
    endfunction

    // tan(pi*f) in q.24 by rotation
    function automatic longint tan_of_freq(input longint fq);
        longint x, y, z, dx, dy, g;
        x = longint'(1) << 29;
        y = 0;
        z = (fq * 64'd3373259426) >>> 24;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_q30(i);
            end else begin
                x += dx; y -= dy; z += arctan_q30(i);
            end
        end
        if (y < 0) y = 0;
        if (x <= 0) return 64'sd2147483647;
        g = (y <<< 24) / x;
        if (g > 64'sd2147483647) g = 64'sd2147483647;
        return g;
    endfunction

    // expected output of one request, updates the filter state
    function automatic t_result lowpass_step(input t_item it);
        t_result r;
        longint cut, fq, g, x30, s, lp, ns, o;
        r.channel_out = it.channel;
        r.sample_out = '0;
        if (it.req_type == REQ_CLEAR) begin
            foreach (lp_state[k]) lp_state[k] = '0;
            return r;
        end
        if (it.channel >= NUM_CH) return r;
        cut = it.cutoff_hz;
        if (cut <= 0) fq = 0;
        else if (rate_hz == 0) fq = longint'(F_MAX_Q24);
        else begin
            fq = (cut <<< 24) / longint'(rate_hz);
            if (fq > longint'(F_MAX_Q24)) fq = longint'(F_MAX_Q24);
        end
        g = tan_of_freq(fq);
        x30 = longint'(it.sample_in) * 128;
        s = lp_state[it.channel];
        lp = (g * x30 + s * (longint'(1) << 24)) / ((longint'(1) << 24) + g);
        ns = floor_shift(g * (x30 - lp), 24) + lp;
        if (ns > 64'sd2147483647) ns = 64'sd2147483647;
        if (ns < -64'sd2147483648) ns = -64'sd2147483648;
        lp_state[it.channel] = ns[31:0];
        o = floor_shift(lp, 7);
        if (o > 8388607) o = 8388607;
        if (o < -8388608) o = -8388608;
        r.sample_out = o[23:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tpt_one_pole_lowpass_core_tb NOT OK");
            $finish;
        end
    end

    // long receiver stall, counted down in cycles
    always @(posedge i_clk) begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // request driver
    int send_gap = 0;
    initial begin
        req_if.valid = 1'b0;
        req_if.req_type = REQ_FILTER;
        req_if.channel = '0;
        req_if.sample_in = '0;
        req_if.cutoff_hz = '0;
    end
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_q.push_back(lowpass_step({req_if.req_type, req_if.channel,
                                                   req_if.sample_in, req_if.cutoff_hz}));
            end
            if (!req_if.valid || req_if.ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    req_if.valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    t_item it;
                    it = pending_q.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.req_type <= it.req_type;
                    req_if.channel <= it.channel;
                    req_if.sample_in <= it.sample_in;
                    req_if.cutoff_hz <= it.cutoff_hz;
                    send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stalls
    int recv_gap = 0;
    initial res_if.ready = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    t_result e;
                    e = expected_q.pop_front();
                    if (res_if.channel_out !== e.channel_out)
                        report_mismatch($sformatf("channel_out %0d, expected %0d",
                                                  res_if.channel_out, e.channel_out));
                    if (res_if.sample_out !== e.sample_out)
                        report_mismatch($sformatf("ch %0d sample_out %0d, expected %0d",
                                                  e.channel_out, res_if.sample_out,
                                                  e.sample_out));
                end
            end
            if (hold_off > 0) begin
                res_if.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if (res_if.valid && res_if.ready)
                    recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            end
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'd0) rate_hz = data[17:0];
    endtask

    // wait for all queued requests to be answered, then for the block to settle
    task automatic drain();
        while (pending_q.size() > 0 || req_if.valid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_item rand_item();
        t_item it;
        int sel;
        it.req_type = ($urandom_range(0, 49) == 0) ? REQ_CLEAR : REQ_FILTER;
        it.channel = 3'($urandom_range(0, 7));
        it.sample_in = 24'($urandom);
        sel = $urandom_range(0, 9);
        if (sel == 0) it.cutoff_hz = 18'($urandom);
        else if (sel == 1) it.cutoff_hz = 18'($urandom_range(90000, 131071));
        else it.cutoff_hz = 18'($urandom_range(0, 24000));
        return it;
    endfunction

    initial begin
        logic [17:0] rates [6] = '{18'd8000, 18'd192000, 18'd44100, 18'd0,
                                   18'd262143, 18'd1};
        rate_hz = SR_RESET;
        foreach (lp_state[k]) lp_state[k] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, clear, negative cutoff, bypassed clipping
        pending_q.push_back('{REQ_FILTER, 3'd0, 24'sh7FFFFF, 18'sd1000});
        pending_q.push_back('{REQ_FILTER, 3'd0, 24'sh7FFFFF, 18'sd1000});
        pending_q.push_back('{REQ_FILTER, 3'd7, -24'sh800000, 18'sd131071});
        pending_q.push_back('{REQ_FILTER, 3'd7, -24'sh800000, 18'sd131071});
        pending_q.push_back('{REQ_FILTER, 3'd1, 24'sd12345, -18'sd131072});
        pending_q.push_back('{REQ_FILTER, 3'd2, 24'sd0, 18'sd0});
        pending_q.push_back('{REQ_FILTER, 3'd3, 24'sh7FFFFF, 18'sd23856});
        pending_q.push_back('{REQ_FILTER, 3'd3, -24'sh800000, 18'sd23856});
        pending_q.push_back('{REQ_FILTER, 3'd4, -24'sd1, 18'sd1});
        pending_q.push_back('{REQ_CLEAR, 3'd5, 24'sh7FFFFF, 18'sd500});
        pending_q.push_back('{REQ_FILTER, 3'd0, 24'sd0, 18'sd1000});
        pending_q.push_back('{REQ_FILTER, 3'd6, 24'sh555555, 18'sh2AAAA});
        drain();

        // random phases over several rates
        foreach (rates[r]) begin
            apb_write(3'd0, {14'd0, rates[r]});
            for (int n = 0; n < 330; n++) pending_q.push_back(rand_item());
            if (r == 2) begin
                // long receiver stall while the sender keeps offering
                wait (expected_q.size() > 0);
                hold_off = 400;
            end
            drain();
        end
        repeat (300) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("tpt_one_pole_lowpass_core_tb OK");
        else
            $display("tpt_one_pole_lowpass_core_tb NOT OK");
        $finish;
    end
endmodule
